// ===== hw/rtl/ttag_pkg.sv =====
// Shared constants for the texture twiddle address generator.
// Register map codes and field widths; no dependencies.
package ttag_pkg;

   // field widths
   localparam int OffsetBits = 20;
   localparam int WordBits   = 32;
   localparam int LogBits    = 4;
   localparam int OriginBits = 10;
   localparam int CountBits  = 11;
   localparam int AddrBits   = 5;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] RegLog2Width  = 3'd0;
   localparam logic [2:0] RegLog2Height = 3'd1;
   localparam logic [2:0] RegOriginX    = 3'd2;
   localparam logic [2:0] RegOriginY    = 3'd3;
   localparam logic [2:0] RegCols       = 3'd4;
   localparam logic [2:0] RegRows       = 3'd5;

   // interleave pattern of one twiddle level
   localparam logic [1:0] LevelYBit = 2'h2;
   localparam logic [1:0] LevelXBit = 2'h1;

endpackage

// ===== hw/rtl/texture_twiddle_address_gen_core.sv =====
// Texture twiddle address generator, top level.
// Depends on ttag_pkg for register codes and field widths.
//
// Usage: software programs the texture size (log2 width, log2 height) and the
// update region (origin, columns, rows) over the csr_ port, then streams the
// region's pixels in scan order into req_. Each accepted word yields one rsp_
// word carrying the twiddled texel offset, the pixel value and tlast on the
// region's final pixel; after that pixel the walk rewinds to the region start.
// Any register write also rewinds the walk.
// rsp_tvalid rises in the cycle after req_ acceptance. Throughput: one word
// per cycle while the output is not stalled; the masked increment and the offset
// OR sit between the request handshake and the single output register.
// Stall: the output register holds its word while rsp_tready is low, and
// req_tready follows rsp_tready whenever that register is full, so a word is
// taken in the same cycle the previous one leaves.
// Reset: registers return to a 1x1 texture with a 1x1 region at the origin;
// every pixel then maps to offset 0 with tlast high. No clearing pass.
module texture_twiddle_address_gen_core #(
   parameter int MAX_LOG2_SIZE = 10,
   parameter int PIXEL_BITS    = 32
) (
   input  logic        clock,
   input  logic        reset,
   // config port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [ttag_pkg::AddrBits-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   // pixel input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] pixel_word
   // texel output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [19:0] texel_offset, [51:20] texel_word, [55:52] zero
   output logic        rsp_tlast    // region_last
);

   localparam int OB = ttag_pkg::OffsetBits;
   localparam int CB = ttag_pkg::CountBits;
   localparam int WordKeep = (PIXEL_BITS < ttag_pkg::WordBits) ? PIXEL_BITS
                                                              : ttag_pkg::WordBits;
   localparam logic [31:0] WordMask = 32'((64'h1 << WordKeep) - 64'h1);
   localparam logic [4:0]  MaxLog2  = 5'(MAX_LOG2_SIZE);

   // configuration registers
   logic [3:0]    log2_w_ff, log2_h_ff;
   logic [9:0]    origin_x_ff, origin_y_ff;
   logic [CB-1:0] cols_ff, rows_ff;

   // walk state
   logic          rewind_ff;
   logic [OB-1:0] col_ff, col_in;
   logic [OB-1:0] row_ff, row_in;
   logic [CB-1:0] col_cnt_ff, col_cnt_in;
   logic [CB-1:0] row_cnt_ff, row_cnt_in;

   // output register
   logic          out_valid_ff;
   logic [OB-1:0] out_offset_ff;
   logic [31:0]   out_word_ff;
   logic          out_last_ff;

   logic          cfg_wr;
   logic [2:0]    cfg_idx;
   logic          accept;

   logic [4:0]    lw, lh, lmin;
   logic [5:0]    two_min, lsum;
   logic          w_longer, h_longer;
   logic [OB-1:0] x_mask, y_mask, dep_x, dep_y;
   logic [OB-1:0] cur_col, cur_row;
   logic [CB-1:0] cols_eff, rows_eff;
   logic          last_col, last_pix;

   assign cfg_wr  = csr_psel & csr_penable & csr_pwrite;
   assign cfg_idx = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   // register readback
   always_comb begin
      case (cfg_idx)
         ttag_pkg::RegLog2Width:  csr_prdata = {28'd0, log2_w_ff};
         ttag_pkg::RegLog2Height: csr_prdata = {28'd0, log2_h_ff};
         ttag_pkg::RegOriginX:    csr_prdata = {22'd0, origin_x_ff};
         ttag_pkg::RegOriginY:    csr_prdata = {22'd0, origin_y_ff};
         ttag_pkg::RegCols:       csr_prdata = {21'd0, cols_ff};
         ttag_pkg::RegRows:       csr_prdata = {21'd0, rows_ff};
         default:                 csr_prdata = 32'd0;
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         log2_w_ff   <= '0;
         log2_h_ff   <= '0;
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         cols_ff     <= CB'(1);
         rows_ff     <= CB'(1);
      end else if (cfg_wr) begin
         case (cfg_idx)
            ttag_pkg::RegLog2Width:  log2_w_ff   <= csr_pwdata[3:0];
            ttag_pkg::RegLog2Height: log2_h_ff   <= csr_pwdata[3:0];
            ttag_pkg::RegOriginX:    origin_x_ff <= csr_pwdata[9:0];
            ttag_pkg::RegOriginY:    origin_y_ff <= csr_pwdata[9:0];
            ttag_pkg::RegCols:       cols_ff     <= csr_pwdata[CB-1:0];
            ttag_pkg::RegRows:       rows_ff     <= csr_pwdata[CB-1:0];
            default: ;
         endcase
      end
   end

   // saturated sizes and level split
   always_comb begin
      lw       = ({1'b0, log2_w_ff} > MaxLog2) ? MaxLog2 : {1'b0, log2_w_ff};
      lh       = ({1'b0, log2_h_ff} > MaxLog2) ? MaxLog2 : {1'b0, log2_h_ff};
      lmin     = (lw < lh) ? lw : lh;
      two_min  = {lmin, 1'b0};
      lsum     = {1'b0, lw} + {1'b0, lh};
      w_longer = lw > lh;
      h_longer = lh > lw;
   end

   // per-bit masks and origin deposits: interleaved levels, then linear bits
   always_comb begin
      logic [5:0] pos;
      logic [4:0] lin_idx;
      logic       in_level, in_linear;
      x_mask = '0;
      y_mask = '0;
      dep_x  = '0;
      dep_y  = '0;
      for (int p = 0; p < OB; p++) begin
         pos       = 6'(p);
         lin_idx   = 5'(pos - {1'b0, lmin});
         in_level  = pos < two_min;
         in_linear = (pos >= two_min) && (pos < lsum);
         if (in_level) begin
            if (pos[0]) begin
               y_mask[p] = ttag_pkg::LevelYBit[1];
               dep_y[p]  = origin_y_ff[pos[4:1]];
            end else begin
               x_mask[p] = ttag_pkg::LevelXBit[0];
               dep_x[p]  = origin_x_ff[pos[4:1]];
            end
         end else if (in_linear) begin
            if (w_longer) begin
               x_mask[p] = 1'b1;
               dep_x[p]  = (lin_idx < 5'd10) ? origin_x_ff[lin_idx[3:0]] : 1'b0;
            end else if (h_longer) begin
               y_mask[p] = 1'b1;
               dep_y[p]  = (lin_idx < 5'd10) ? origin_y_ff[lin_idx[3:0]] : 1'b0;
            end
         end
      end
   end

   // current position and end-of-row / end-of-region tests
   assign cur_col  = rewind_ff ? dep_x : col_ff;
   assign cur_row  = rewind_ff ? dep_y : row_ff;
   assign cols_eff = (cols_ff == '0) ? CB'(1) : cols_ff;
   assign rows_eff = (rows_ff == '0) ? CB'(1) : rows_ff;
   assign last_col = ({1'b0, col_cnt_ff} + (CB+1)'(1)) >= {1'b0, cols_eff};
   assign last_pix = last_col &&
                     (({1'b0, row_cnt_ff} + (CB+1)'(1)) >= {1'b0, rows_eff});

   // masked-increment step
   always_comb begin
      col_in     = cur_col;
      row_in     = cur_row;
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (last_pix) begin
         col_in     = dep_x;
         row_in     = dep_y;
         col_cnt_in = '0;
         row_cnt_in = '0;
      end else if (last_col) begin
         col_in     = dep_x;
         row_in     = (cur_row - y_mask) & y_mask;
         col_cnt_in = '0;
         row_cnt_in = row_cnt_ff + CB'(1);
      end else begin
         col_in     = (cur_col - x_mask) & x_mask;
         col_cnt_in = col_cnt_ff + CB'(1);
      end
   end

   assign req_tready = ~out_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   // walk state: a config write rewinds, an accepted word advances
   always_ff @(posedge clock) begin
      if (reset) begin
         rewind_ff  <= 1'b1;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (cfg_wr && cfg_idx <= ttag_pkg::RegRows) begin
         rewind_ff  <= 1'b1;
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (accept) begin
         rewind_ff  <= 1'b0;
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         out_offset_ff <= cur_col | cur_row;
         out_word_ff   <= req_tdata & WordMask;
         out_last_ff   <= last_pix;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_word_ff, out_offset_ff};
   assign rsp_tlast  = out_last_ff;

endmodule
